FILE: design/mnx_pkg.sv
package mnx_pkg;

  // Default sizing of the sample stores
  localparam int MAX_HALF_WIDTH_D = 512;
  localparam int MAX_LAG_RANGE_D  = 64;

  // Field and register widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_H_W  = 10;
  localparam int CFG_L_W  = 7;
  localparam int POS_W    = 11;
  localparam int TOT_W    = 12;
  localparam int Q_W      = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int FRAC_SHIFT = 30;

  localparam logic [POS_W-1:0]   POS_LIMIT = 11'd2047;
  localparam logic [CFG_H_W-1:0] H_RESET   = 10'd20;
  localparam logic [CFG_L_W-1:0] L_RESET   = 7'd10;

  // Register indexes (taken from paddr[2])
  localparam logic REG_HALF_WIDTH = 1'b0;
  localparam logic REG_LAG_RANGE  = 1'b1;

  // Top level sequencer
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MAC,
    ST_UP_START,
    ST_UP_WAIT,
    ST_LO_START,
    ST_LO_WAIT,
    ST_FINISH
  } mnx_state_t;

  // Score unit phases
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL_D,
    SC_MUL_N,
    SC_SEARCH,
    SC_DONE
  } mnx_sc_phase_t;

endpackage

FILE: design/mnx_in_if.sv
interface mnx_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mnx_pkg::SAMPLE_W-1:0] center_sample;
  logic signed [mnx_pkg::SAMPLE_W-1:0] upper_sample;
  logic signed [mnx_pkg::SAMPLE_W-1:0] lower_sample;
  logic                                last_sample;

  modport source (output valid, center_sample, upper_sample, lower_sample, last_sample,
                  input ready);
  modport sink (input valid, center_sample, upper_sample, lower_sample, last_sample,
                output ready);
endinterface

FILE: design/mnx_out_if.sv
interface mnx_out_if;
  logic                         valid;
  logic                         ready;
  logic [mnx_pkg::Q_W-1:0]      similarity;
  logic                         length_error;

  modport source (output valid, similarity, length_error, input ready);
  modport sink (input valid, similarity, length_error, output ready);
endinterface

FILE: design/mnx_store.sv
module mnx_store #(
  parameter int MAX_HALF_WIDTH = mnx_pkg::MAX_HALF_WIDTH_D,
  parameter int MAX_LAG_RANGE  = mnx_pkg::MAX_LAG_RANGE_D
) (
  input  logic                                clk,
  input  logic                                wr_n_en,
  input  logic [$clog2(2*MAX_HALF_WIDTH+2*MAX_LAG_RANGE+1)-1:0] wr_n_addr,
  input  logic signed [mnx_pkg::SAMPLE_W-1:0] wr_upper,
  input  logic signed [mnx_pkg::SAMPLE_W-1:0] wr_lower,
  input  logic                                wr_r_en,
  input  logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0] wr_r_addr,
  input  logic signed [mnx_pkg::SAMPLE_W-1:0] wr_center,
  input  logic                                rd_en,
  input  logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0] rd_r_addr,
  input  logic [$clog2(2*MAX_HALF_WIDTH+2*MAX_LAG_RANGE+1)-1:0] rd_n_addr,
  output logic signed [mnx_pkg::SAMPLE_W-1:0] rd_ref,
  output logic signed [mnx_pkg::SAMPLE_W-1:0] rd_upper,
  output logic signed [mnx_pkg::SAMPLE_W-1:0] rd_lower
);
  import mnx_pkg::*;

  localparam int REF_DEPTH = 2*MAX_HALF_WIDTH + 1;
  localparam int NBR_DEPTH = 2*MAX_HALF_WIDTH + 2*MAX_LAG_RANGE + 1;

  logic signed [SAMPLE_W-1:0] ref_mem [REF_DEPTH];
  logic signed [SAMPLE_W-1:0] up_mem  [NBR_DEPTH];
  logic signed [SAMPLE_W-1:0] lo_mem  [NBR_DEPTH];

  // Reference window
  always_ff @(posedge clk) begin
    if (wr_r_en) begin
      ref_mem[wr_r_addr] <= wr_center;
    end
    if (rd_en) begin
      rd_ref <= ref_mem[rd_r_addr];
    end
  end

  // Neighbour channels share one address
  always_ff @(posedge clk) begin
    if (wr_n_en) begin
      up_mem[wr_n_addr] <= wr_upper;
      lo_mem[wr_n_addr] <= wr_lower;
    end
    if (rd_en) begin
      rd_upper <= up_mem[rd_n_addr];
      rd_lower <= lo_mem[rd_n_addr];
    end
  end

endmodule

FILE: design/mnx_score.sv
module mnx_score #(
  parameter int EW = 41
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [EW-1:0]          c_abs,
  input  logic [EW-1:0]          er,
  input  logic [EW-1:0]          ex,
  output logic                   done,
  output logic [mnx_pkg::Q_W-1:0] q
);
  import mnx_pkg::*;

  localparam int SW = 2*EW + 32;
  localparam int CW = $clog2(EW);

  mnx_sc_phase_t phase_r, phase_nxt;

  logic [SW-1:0]  ma_r, acc_r, d_r, n_r, y_r, z_r;
  logic [EW-1:0]  mb_r, c_hold_r;
  logic [CW-1:0]  cnt_r;
  logic [3:0]     bit_r;
  logic [Q_W-1:0] q_r;
  logic           zero_r;

  logic [SW-1:0]  acc_sum, trial;
  logic           mul_last, take;

  // One shift-add step per cycle
  assign acc_sum  = acc_r + (mb_r[0] ? ma_r : '0);
  assign mul_last = (cnt_r == CW'(EW-1));

  // Test q + 2^bit: (q+b)^2 D = qqD + 2qbD + bbD
  assign trial = y_r + (z_r << ({1'b0, bit_r} + 5'd1)) + (d_r << {bit_r, 1'b0});
  assign take  = !q_r[Q_W-1] && !zero_r && (trial <= n_r);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      SC_IDLE:   if (start) phase_nxt = SC_MUL_D;
      SC_MUL_D:  if (mul_last) phase_nxt = SC_MUL_N;
      SC_MUL_N:  if (mul_last) phase_nxt = SC_SEARCH;
      SC_SEARCH: if (bit_r == 4'd0) phase_nxt = SC_DONE;
      SC_DONE:   phase_nxt = SC_IDLE;
      default:   phase_nxt = SC_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (phase_r == SC_DONE);
    q    = q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SC_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (phase_r)
      SC_IDLE: begin
        ma_r     <= SW'(er);
        mb_r     <= ex;
        acc_r    <= '0;
        cnt_r    <= '0;
        c_hold_r <= c_abs;
        zero_r   <= (er == '0) || (ex == '0);
      end
      SC_MUL_D: begin
        if (mul_last) begin
          d_r   <= acc_sum;
          ma_r  <= SW'(c_hold_r);
          mb_r  <= c_hold_r;
          acc_r <= '0;
          cnt_r <= '0;
        end else begin
          acc_r <= acc_sum;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      SC_MUL_N: begin
        if (mul_last) begin
          n_r   <= acc_sum << FRAC_SHIFT;
          y_r   <= '0;
          z_r   <= '0;
          q_r   <= '0;
          bit_r <= 4'd15;
        end else begin
          acc_r <= acc_sum;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      SC_SEARCH: begin
        if (take) begin
          y_r        <= trial;
          z_r        <= z_r + (d_r << bit_r);
          q_r[bit_r] <= 1'b1;
        end
        bit_r <= bit_r - 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/max_normalized_xcorr_similarity.sv
// Flow: a run of N items is loaded at one item per cycle while in_ch.ready is high;
// after the last transfer, each of the 2L+1 lags is swept through the store reads,
// then scored in two passes (upper, then lower) by the serial multiply and search
// unit (EW = 41 by default); ST_FINISH then raises the result after the last lag.
// Input stalls for the whole lag sweep. A wrong-length run gives
// its result next cycle. Reset: synchronous, active low; H = 20, L = 10.
module max_normalized_xcorr_similarity #(
  parameter int MAX_HALF_WIDTH = mnx_pkg::MAX_HALF_WIDTH_D,
  parameter int MAX_LAG_RANGE  = mnx_pkg::MAX_LAG_RANGE_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mnx_in_if.sink                       in_ch,
  mnx_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mnx_pkg::PADDR_W-1:0]  paddr,
  input  logic [mnx_pkg::PDATA_W-1:0]  pwdata,
  output logic [mnx_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import mnx_pkg::*;

  localparam int REF_DEPTH = 2*MAX_HALF_WIDTH + 1;
  localparam int NBR_DEPTH = 2*MAX_HALF_WIDTH + 2*MAX_LAG_RANGE + 1;
  localparam int RA = $clog2(REF_DEPTH);
  localparam int NA = $clog2(NBR_DEPTH);
  localparam int KW = $clog2(2*MAX_LAG_RANGE + 2);
  localparam int EW = 2*(SAMPLE_W-1) + $clog2(2*MAX_HALF_WIDTH + 2);
  localparam int PW = 2*SAMPLE_W;

  // Configuration registers
  logic [CFG_H_W-1:0] cfg_h_r;
  logic [CFG_L_W-1:0] cfg_l_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_h_r <= H_RESET;
      cfg_l_r <= L_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_HALF_WIDTH: cfg_h_r <= pwdata[CFG_H_W-1:0];
        REG_LAG_RANGE:  cfg_l_r <= pwdata[CFG_L_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HALF_WIDTH: prdata = PDATA_W'(cfg_h_r);
      REG_LAG_RANGE:  prdata = PDATA_W'(cfg_l_r);
      default:        prdata = '0;
    endcase
  end

  // Effective sizes, clamped to the store depths
  logic [TOT_W-1:0] h_eff, l_eff, w_len, total;
  assign h_eff = (cfg_h_r > MAX_HALF_WIDTH) ? TOT_W'(MAX_HALF_WIDTH) : TOT_W'(cfg_h_r);
  assign l_eff = (cfg_l_r > MAX_LAG_RANGE) ? TOT_W'(MAX_LAG_RANGE) : TOT_W'(cfg_l_r);
  assign w_len = (h_eff << 1) + TOT_W'(1);
  assign total = w_len + (l_eff << 1);

  mnx_state_t state_r, state_nxt;

  logic [POS_W-1:0] pos_r;
  logic             accept, len_ok;
  logic [TOT_W-1:0] pos_ext, ref_off;

  assign accept  = in_ch.valid && in_ch.ready;
  assign pos_ext = TOT_W'(pos_r);
  assign ref_off = pos_ext - l_eff;
  assign len_ok  = (pos_ext + TOT_W'(1)) == total;

  // Correlation sweep counters and pipeline flags
  logic [RA-1:0] i_r;
  logic [KW-1:0] k_r;
  logic          issue_done_r, v1_r, v2_r, rd_en, mac_drained, last_lag;

  assign mac_drained = issue_done_r && !v1_r && !v2_r;
  assign last_lag    = TOT_W'(k_r) == (l_eff << 1);

  // Score unit handshake
  logic           sc_start, sc_done;
  logic [Q_W-1:0] sc_q;
  logic [EW-1:0]  sc_c;
  logic [EW-1:0]  sc_ex;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (accept && in_ch.last_sample && len_ok) state_nxt = ST_MAC;
      ST_MAC:      if (mac_drained) state_nxt = ST_UP_START;
      ST_UP_START: state_nxt = ST_UP_WAIT;
      ST_UP_WAIT:  if (sc_done) state_nxt = ST_LO_START;
      ST_LO_START: state_nxt = ST_LO_WAIT;
      ST_LO_WAIT:  if (sc_done) state_nxt = last_lag ? ST_FINISH : ST_MAC;
      ST_FINISH:   state_nxt = ST_LOAD;
      default:     state_nxt = ST_LOAD;
    endcase
  end

  logic out_valid_r;

  // Control outputs
  always_comb begin
    in_ch.ready = (state_r == ST_LOAD) && (!out_valid_r || !in_ch.last_sample);
    rd_en       = (state_r == ST_MAC) && !issue_done_r;
    sc_start    = (state_r == ST_UP_START) || (state_r == ST_LO_START);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sample position within the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      if (in_ch.last_sample) begin
        pos_r <= '0;
      end else if (pos_r != POS_LIMIT) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  // Sample stores
  logic signed [SAMPLE_W-1:0] rd_ref, rd_up, rd_lo;

  mnx_store #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .MAX_LAG_RANGE  (MAX_LAG_RANGE)
  ) u_store (
    .clk       (clk),
    .wr_n_en   (accept && (pos_ext < total)),
    .wr_n_addr (pos_ext[NA-1:0]),
    .wr_upper  (in_ch.upper_sample),
    .wr_lower  (in_ch.lower_sample),
    .wr_r_en   (accept && (pos_ext >= l_eff) && (ref_off < w_len)),
    .wr_r_addr (ref_off[RA-1:0]),
    .wr_center (in_ch.center_sample),
    .rd_en     (rd_en),
    .rd_r_addr (i_r),
    .rd_n_addr (NA'(i_r) + NA'(k_r)),
    .rd_ref    (rd_ref),
    .rd_upper  (rd_up),
    .rd_lower  (rd_lo)
  );

  // Product stage
  logic signed [PW-1:0] p_rr_r, p_ru_r, p_rl_r, p_uu_r, p_ll_r;

  always_ff @(posedge clk) begin
    p_rr_r <= rd_ref * rd_ref;
    p_ru_r <= rd_ref * rd_up;
    p_rl_r <= rd_ref * rd_lo;
    p_uu_r <= rd_up * rd_up;
    p_ll_r <= rd_lo * rd_lo;
  end

  // Accumulators for one lag
  logic signed [EW:0] cu_r, cl_r;
  logic [EW-1:0]      er_r, eu_r, el_r;
  logic               mac_enter;

  assign mac_enter = (state_r != ST_MAC) && (state_nxt == ST_MAC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_done_r <= 1'b1;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      if (mac_enter) begin
        issue_done_r <= 1'b0;
      end else if (rd_en && (TOT_W'(i_r) == w_len - TOT_W'(1))) begin
        issue_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_enter) begin
      i_r  <= '0;
      cu_r <= '0;
      cl_r <= '0;
      er_r <= '0;
      eu_r <= '0;
      el_r <= '0;
    end else begin
      if (rd_en) begin
        i_r <= i_r + 1'b1;
      end
      if (v2_r) begin
        cu_r <= cu_r + (EW+1)'(p_ru_r);
        cl_r <= cl_r + (EW+1)'(p_rl_r);
        er_r <= er_r + EW'($unsigned(p_rr_r));
        eu_r <= eu_r + EW'($unsigned(p_uu_r));
        el_r <= el_r + EW'($unsigned(p_ll_r));
      end
    end
  end

  // Lag counter: held at zero while a run loads, stepped after each lag but the last
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      k_r <= '0;
    end else if ((state_r == ST_LO_WAIT) && sc_done && !last_lag) begin
      k_r <= k_r + 1'b1;
    end
  end

  // Score selection
  logic upper_pass;
  assign upper_pass = (state_r == ST_UP_START) || (state_r == ST_UP_WAIT);

  always_comb begin
    if (upper_pass) begin
      sc_c  = cu_r[EW] ? EW'(-cu_r) : EW'(cu_r);
      sc_ex = eu_r;
    end else begin
      sc_c  = cl_r[EW] ? EW'(-cl_r) : EW'(cl_r);
      sc_ex = el_r;
    end
  end

  mnx_score #(
    .EW (EW)
  ) u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .c_abs (sc_c),
    .er    (er_r),
    .ex    (sc_ex),
    .done  (sc_done),
    .q     (sc_q)
  );

  // Best score per neighbour
  logic [Q_W-1:0] best_up_r, best_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_up_r <= '0;
      best_lo_r <= '0;
    end else if (accept && in_ch.last_sample) begin
      best_up_r <= '0;
      best_lo_r <= '0;
    end else if (sc_done) begin
      if ((state_r == ST_UP_WAIT) && (sc_q > best_up_r)) begin
        best_up_r <= sc_q;
      end
      if ((state_r == ST_LO_WAIT) && (sc_q > best_lo_r)) begin
        best_lo_r <= sc_q;
      end
    end
  end

  // Result register
  logic [Q_W:0]   best_sum;
  logic [Q_W-1:0] sim_r;
  logic           err_r;

  assign best_sum = {1'b0, best_up_r} + {1'b0, best_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (accept && in_ch.last_sample && !len_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH) begin
      sim_r <= best_sum[Q_W:1];
      err_r <= 1'b0;
    end else if (accept && in_ch.last_sample && !len_ok) begin
      sim_r <= '0;
      err_r <= 1'b1;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.similarity   = sim_r;
  assign out_ch.length_error = err_r;

  // Checks
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << (Q_W-1);

  a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (sim_r <= Q_ONE))
    else $error("similarity above one");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r) |-> (sim_r == '0))
    else $error("length error with non-zero similarity");

  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> ((32'(i_r) + 32'(k_r)) < NBR_DEPTH))
    else $error("neighbour read beyond store");

  a_score_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sc_done |-> ((state_r == ST_UP_WAIT) || (state_r == ST_LO_WAIT)))
    else $error("score finished outside a score wait");

endmodule

FILE: bench/max_normalized_xcorr_similarity_tb.sv
`timescale 1ns / 100ps

module max_normalized_xcorr_similarity_tb;
  import mnx_pkg::*;

  localparam int HW_CAP   = MAX_HALF_WIDTH_D;
  localparam int LAG_CAP  = MAX_LAG_RANGE_D;
  localparam int REF_SZ   = 2 * HW_CAP + 1;
  localparam int NBR_SZ   = 2 * HW_CAP + 2 * LAG_CAP + 1;
  localparam int Q_FULL   = 32768;
  localparam int HOLD_LEN = 3000;

  // Sample patterns for a run
  localparam int PAT_RANDOM  = 0;
  localparam int PAT_TINY    = 1;
  localparam int PAT_RAILS   = 2;
  localparam int PAT_MIRROR  = 3;
  localparam int PAT_DEAD    = 4;

  typedef struct packed {
    logic [Q_W-1:0] sim;
    logic           len_err;
  } sim_result_t;

  // Scoreboard: mirrors the block's stores and predicts the similarity per run
  class sim_scoreboard;
    int unsigned half_w;
    int unsigned lag_r;
    logic signed [SAMPLE_W-1:0] ref_mem [REF_SZ];
    logic signed [SAMPLE_W-1:0] up_mem [NBR_SZ];
    logic signed [SAMPLE_W-1:0] lo_mem [NBR_SZ];
    int unsigned pos;
    sim_result_t expected_q[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned len_errs_seen;
    int unsigned full_scores;

    function void clear();
      half_w = H_RESET;
      lag_r  = L_RESET;
      pos    = 0;
      foreach (ref_mem[i]) ref_mem[i] = '0;
      foreach (up_mem[i]) begin
        up_mem[i] = '0;
        lo_mem[i] = '0;
      end
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    // largest q with q^2 * er * ex <= 2^30 * c^2
    function int unsigned q15_score(longint unsigned c, longint unsigned er,
                                    longint unsigned ex);
      bit [127:0] den, num, t;
      int unsigned lo, hi, mid;
      if (er == 0 || ex == 0) return 0;
      den = 128'(er) * 128'(ex);
      num = (128'(c) * 128'(c)) << FRAC_SHIFT;
      lo = 0;
      hi = Q_FULL;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t = den * 128'(mid * mid);
        if (t <= num) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function void note_input(logic signed [SAMPLE_W-1:0] c, logic signed [SAMPLE_W-1:0] u,
                             logic signed [SAMPLE_W-1:0] d, logic last);
      int unsigned h, l, w, total, p, bu, bl, su, sl;
      longint er, cu, cl, eu, el, r, xu, xl;
      sim_result_t res;
      h = half_w > HW_CAP ? HW_CAP : half_w;
      l = lag_r > LAG_CAP ? LAG_CAP : lag_r;
      w = 2 * h + 1;
      total = w + 2 * l;
      p = pos;
      if (p < total && p < NBR_SZ) begin
        up_mem[p] = u;
        lo_mem[p] = d;
      end
      if (p >= l && p - l < w) ref_mem[p - l] = c;
      if (!last) begin
        pos = p < POS_LIMIT ? p + 1 : POS_LIMIT;
        return;
      end
      pos = 0;
      if (p + 1 != total) begin
        res.sim = '0;
        res.len_err = 1'b1;
        expected_q.push_back(res);
        return;
      end
      er = 0;
      for (int i = 0; i < w; i++) er += longint'(ref_mem[i]) * longint'(ref_mem[i]);
      bu = 0;
      bl = 0;
      for (int k = 0; k <= 2 * l; k++) begin
        cu = 0; cl = 0; eu = 0; el = 0;
        for (int i = 0; i < w; i++) begin
          r  = ref_mem[i];
          xu = up_mem[i + k];
          xl = lo_mem[i + k];
          cu += r * xu;
          cl += r * xl;
          eu += xu * xu;
          el += xl * xl;
        end
        su = q15_score(cu < 0 ? -cu : cu, er, eu);
        sl = q15_score(cl < 0 ? -cl : cl, er, el);
        if (su > bu) bu = su;
        if (sl > bl) bl = sl;
      end
      res.sim = Q_W'((bu + bl) >> 1);
      res.len_err = 1'b0;
      expected_q.push_back(res);
    endfunction

    task check_result(logic [Q_W-1:0] sim, logic len_err);
      sim_result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result sim=%0d len_err=%0b", sim, len_err));
        return;
      end
      exp_r = expected_q.pop_front();
      if (len_err) len_errs_seen++;
      if (sim == Q_FULL) full_scores++;
      if (sim !== exp_r.sim)
        report($sformatf("similarity %0d, expected %0d", sim, exp_r.sim));
      if (len_err !== exp_r.len_err)
        report($sformatf("length_error %0b, expected %0b", len_err, exp_r.len_err));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  mnx_in_if  in_ch();
  mnx_out_if out_ch();

  max_normalized_xcorr_similarity u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sim_scoreboard sb = new();
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned hold_asked;
  int unsigned hold_done;
  int unsigned cfg_count;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver: stall pattern changes at random intervals; long hold on request
  initial begin
    int mode, mode_left, hold_left, stretch;
    out_ch.ready = 1'b0;
    mode = 0; mode_left = 0; hold_left = 0; stretch = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_LEN;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(100, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= (mode_left % 4 == 0);
          default: begin
            if (stretch == 0) stretch = $urandom_range(1, 30);
            stretch--;
            out_ch.ready <= (stretch < 5);
          end
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.similarity, out_ch.length_error);
  end

  initial begin
    #10_000_000;
    $display("[max_normalized_xcorr_similarity] ERROR");
    $finish;
  end

  task go_quiet();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task wait_drained();
    go_quiet();
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // Register write then read-back; only while idle
  task cfg_access(logic idx, logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] got, want;
    wait_drained();
    repeat (20) @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    if (idx == REG_HALF_WIDTH) sb.half_w = val[CFG_H_W-1:0];
    else sb.lag_r = val[CFG_L_W-1:0];
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    want = (idx == REG_HALF_WIDTH) ? sb.half_w : sb.lag_r;
    if (got !== want)
      sb.report($sformatf("register %0d reads %0d, expected %0d", idx, got, want));
    cfg_count++;
  endtask

  task set_shape(int unsigned h, int unsigned l);
    cfg_access(REG_HALF_WIDTH, h);
    cfg_access(REG_LAG_RANGE, l);
  endtask

  // One input transfer, with bursty idling in front of it
  task send_item(logic signed [SAMPLE_W-1:0] c, logic signed [SAMPLE_W-1:0] u,
                 logic signed [SAMPLE_W-1:0] d, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.center_sample <= c;
    in_ch.upper_sample <= u;
    in_ch.lower_sample <= d;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(c, u, d, last);
    items_sent++;
    @(negedge clk);
  endtask

  function logic signed [SAMPLE_W-1:0] pick(int pat);
    case (pat)
      PAT_TINY:  return SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
      PAT_RAILS: case ($urandom_range(0, 3))
                   0: return 16'sh8000;
                   1: return 16'sh7fff;
                   2: return 16'sh8001;
                   default: return 16'sh0000;
                 endcase
      PAT_DEAD:  return 16'sh0000;
      default:   return SAMPLE_W'($urandom);
    endcase
  endfunction

  // A run of n steps; last flag on the final one
  task send_run(int unsigned n, int pat);
    logic signed [SAMPLE_W-1:0] c, u, d;
    for (int unsigned i = 0; i < n; i++) begin
      c = pick(pat == PAT_MIRROR ? PAT_RANDOM : pat);
      if (pat == PAT_MIRROR) begin
        if (c == 16'sh8000) c = 16'sh8001;
        u = c;
        d = -c;
      end else if (pat == PAT_DEAD) begin
        u = pick(PAT_RANDOM);
        d = pick(PAT_DEAD);
      end else begin
        u = pick(pat);
        d = pick(pat);
      end
      send_item(c, u, d, i == n - 1);
    end
  endtask

  function int unsigned run_len();
    int unsigned h, l;
    h = sb.half_w > HW_CAP ? HW_CAP : sb.half_w;
    l = sb.lag_r > LAG_CAP ? LAG_CAP : sb.lag_r;
    return 2 * (h + l) + 1;
  endfunction

  initial begin
    int unsigned rand_items, n, tot;
    bit held;
    sb.clear();
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.center_sample = '0;
    in_ch.upper_sample = '0;
    in_ch.lower_sample = '0;
    in_ch.last_sample = 1'b0;
    items_sent = 0; burst_left = 0; hold_asked = 0; hold_done = 0; cfg_count = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset shape, perfect match, silent channels, rails, bad lengths, tiny values
    send_run(run_len(), PAT_MIRROR);
    set_shape(1, 0);
    send_run(3, PAT_MIRROR);
    send_run(3, PAT_DEAD);
    send_run(3, PAT_RAILS);
    send_run(1, PAT_RANDOM);
    send_run(5, PAT_RANDOM);
    set_shape(0, 1);
    send_run(3, PAT_RANDOM);
    send_run(3, PAT_TINY);
    wait_drained();

    // Random: largest shape (above the caps), one at full lag, then small shapes
    rand_items = items_sent;
    set_shape(1023, 127);
    send_run(run_len(), PAT_RANDOM);
    rand_items += run_len();
    set_shape(1, 64);
    send_run(run_len(), PAT_TINY);
    rand_items += run_len();
    held = 0;
    while (rand_items < 1850) begin
      set_shape($urandom_range(0, 8), $urandom_range(0, 4));
      repeat ($urandom_range(3, 8)) begin
        tot = run_len();
        if ($urandom_range(0, 99) < 85) n = tot;
        else begin
          n = $urandom_range(1, tot + 3);
          if (n == tot) n = tot + 1;
        end
        send_run(n, $urandom_range(0, 4));
        rand_items += n;
        if (!held && rand_items > 1500) begin
          held = 1;
          hold_asked++;
        end
      end
    end

    // Wind down
    wait_drained();
    repeat (50) @(negedge clk);
    $display("Sent %0d steps over %0d register writes; %0d results checked",
             items_sent, cfg_count, sb.results_seen);
    $display("  of which %0d flagged bad length and %0d scored full similarity",
             sb.len_errs_seen, sb.full_scores);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[max_normalized_xcorr_similarity] OK");
    end else begin
      $display("[max_normalized_xcorr_similarity] ERROR");
    end
    $finish;
  end

endmodule
